// ----- hdl/bezier_curve_point_evaluator_macros.svh -----
// Assertion helpers for the evaluator RTL.
`ifndef BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BCPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bcpe_pkg.sv -----
package bcpe_pkg;

    localparam int MAX_POINTS = 16;
    localparam int COORD_W    = 24;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 5;
    localparam int T_W        = 17;
    localparam int FRAC_W     = 16;

    localparam logic [T_W-1:0]   T_ONE   = T_W'(65536);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        logic                     cmd;
        logic [3:0]               point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [T_W-1:0]           param_t;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
    } out_t;

    // valid plus destination slot for an interpolation in flight
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

// ----- hdl/bezier_curve_point_evaluator.sv -----
// De Casteljau evaluator for a Bezier curve of up to 16 control points.
// Input channel (in_valid / in_stall / in_data): a write item stores one
// control point and gives no result; an evaluate item reduces
// the first stored points, as many as the point count, at param_t and gives
// one result on the output channel (out_valid / out_stall / out_data).
// The point count is set through cfg_write / cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce it. Each
// level of the reduction streams its points, one per cycle, out of the control
// point RAM on the first level and out of the scratch RAM after it, through a
// three-stage subtract / multiply / add pipe (one multiplier per axis), then
// drains the pipe before the next level reads back what was written.
// in_stall is high while an evaluation runs; one item is worked on at a time.
// A finished result sits in the output register; the next item is taken
// while it waits, but a second result holds the block until the first is
// transferred. Reset empties the output and sets the point count to 1; stored
// points are undefined until written.
module bezier_curve_point_evaluator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bcpe_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bcpe_pkg::out_t                out_data,
    input  logic                          cfg_write,
    input  logic [bcpe_pkg::CNT_W-1:0]    cfg_data
);
    import bcpe_pkg::*;

    `include "bezier_curve_point_evaluator_macros.svh"

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RUN     = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_FETCH   = 3'd3;
    localparam logic [2:0] ST_CAPTURE = 3'd4;

    point_t ctrl_mem [MAX_POINTS];
    point_t work_mem [MAX_POINTS];

    logic [2:0]       state_reg,   state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] lvl_reg,     lvl_next;
    logic [IDX_W-1:0] rd_idx_reg,  rd_idx_next;
    logic             src_ctrl_reg, src_ctrl_next;
    logic [T_W-1:0]   t_reg,       t_next;
    logic             out_vld_reg, out_vld_next;
    out_t             out_reg;

    logic             rvld_reg;
    logic             rfirst_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic             rsrc_reg;
    point_t           ctrl_rd_reg;
    point_t           work_rd_reg;
    point_t           a_reg;

    logic             in_xfer;
    logic             run_issue;
    logic             fetch_issue;
    logic             rd_en;
    logic             last_rd;
    logic             cap_load;
    logic [CNT_W-1:0] n_eff;
    logic [T_W-1:0]   t_sat;
    point_t           rdata;
    tag_t             lerp_in_tag;
    tag_t             lerp_out_tag;
    point_t           lerp_res;
    logic             lerp_busy;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign n_eff = (count_reg == '0)     ? CNT_W'(1) :
                   (count_reg > MAX_CNT) ? MAX_CNT   : count_reg;
    assign t_sat = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;

    assign last_rd     = (CNT_W'(rd_idx_reg) == lvl_reg - CNT_W'(1));
    assign run_issue   = (state_reg == ST_RUN);
    assign fetch_issue = (state_reg == ST_FETCH);
    assign rd_en       = run_issue || fetch_issue;
    assign rdata       = rsrc_reg ? ctrl_rd_reg : work_rd_reg;
    assign cap_load    = (state_reg == ST_CAPTURE) && (!out_vld_reg || !out_stall);

    always_comb
    begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        rd_idx_next   = rd_idx_reg;
        src_ctrl_next = src_ctrl_reg;
        t_next        = t_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_data.cmd == CMD_EVAL)
                begin
                    lvl_next      = n_eff;
                    rd_idx_next   = '0;
                    src_ctrl_next = 1'b1;
                    t_next        = t_sat;
                    state_next    = (n_eff == CNT_W'(1)) ? ST_FETCH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_rd)
                    state_next = ST_DRAIN;
                else
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                // next level reads what this one wrote: wait for the last write
                if (!rvld_reg && !lerp_busy)
                begin
                    lvl_next      = lvl_reg - CNT_W'(1);
                    rd_idx_next   = '0;
                    src_ctrl_next = 1'b0;
                    state_next    = (lvl_reg == CNT_W'(2)) ? ST_FETCH : ST_RUN;
                end
            end
            ST_FETCH:
                state_next = ST_CAPTURE;
            ST_CAPTURE:
            begin
                if (cap_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        if (cap_load)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_W'(1);
            out_vld_reg <= 1'b0;
            rvld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            rvld_reg    <= run_issue;
            if (cfg_write)
                count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        rd_idx_reg   <= rd_idx_next;
        src_ctrl_reg <= src_ctrl_next;
        t_reg        <= t_next;
        if (rd_en)
        begin
            rfirst_reg <= (rd_idx_reg == '0);
            ridx_reg   <= rd_idx_reg;
            rsrc_reg   <= src_ctrl_reg;
        end
        if (rvld_reg)
            a_reg <= rdata;
        if (cap_load)
        begin
            out_reg.curve_x <= rdata.x;
            out_reg.curve_y <= rdata.y;
        end
    end

    // control point store
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.cmd == CMD_WRITE
            && CNT_W'(in_data.point_index) < MAX_CNT)
        begin
            ctrl_mem[in_data.point_index[IDX_W-1:0]] <= '{x: in_data.point_x,
                                                           y: in_data.point_y};
        end
        if (rd_en)
            ctrl_rd_reg <= ctrl_mem[rd_idx_reg];
    end

    // scratch store, rewritten level by level
    always_ff @(posedge clk)
    begin
        if (lerp_out_tag.vld)
            work_mem[lerp_out_tag.idx] <= lerp_res;
        if (rd_en)
            work_rd_reg <= work_mem[rd_idx_reg];
    end

    // each point after the first of a level pairs with its predecessor
    assign lerp_in_tag.vld = rvld_reg && !rfirst_reg;
    assign lerp_in_tag.idx = ridx_reg - IDX_W'(1);

    bcpe_lerp u_lerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (lerp_in_tag),
        .a       (a_reg),
        .b       (rdata),
        .t       (t_reg),
        .busy    (lerp_busy),
        .out_tag (lerp_out_tag),
        .res     (lerp_res)
    );

    `BCPE_ASSERT_IMPL(a_wr_in_level, lerp_out_tag.vld,
        state_reg == ST_RUN || state_reg == ST_DRAIN, "scratch write outside a level")
    `BCPE_ASSERT_IMPL(a_run_lvl, state_reg == ST_RUN,
        lvl_reg >= CNT_W'(2) && CNT_W'(rd_idx_reg) < lvl_reg, "read beyond level")
    `BCPE_ASSERT_NEXT(a_cap_hold, state_reg == ST_CAPTURE && out_vld_reg && out_stall,
        state_reg == ST_CAPTURE && out_vld_reg, "result overwrote a pending one")
    `BCPE_ASSERT_NEXT(a_fetch_drained, state_reg == ST_FETCH,
        !lerp_busy && !lerp_out_tag.vld, "final read with writes in flight")

endmodule

// ----- hdl/bcpe_lerp.sv -----
module bcpe_lerp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcpe_pkg::tag_t                in_tag,
    input  bcpe_pkg::point_t              a,
    input  bcpe_pkg::point_t              b,
    input  logic [bcpe_pkg::T_W-1:0]      t,
    output logic                          busy,
    output bcpe_pkg::tag_t                out_tag,
    output bcpe_pkg::point_t              res
);
    import bcpe_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    logic                      s1_vld_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    point_t                    s1_a_reg;
    logic signed [DIFF_W-1:0]  s1_dx_reg;
    logic signed [DIFF_W-1:0]  s1_dy_reg;

    logic                      s2_vld_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    point_t                    s2_a_reg;
    logic signed [PROD_W-1:0]  s2_px_reg;
    logic signed [PROD_W-1:0]  s2_py_reg;

    logic signed [T_W:0]       t_s;

    assign t_s = signed'({1'b0, t});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_tag.vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_tag.idx;
        s1_a_reg   <= a;
        s1_dx_reg  <= DIFF_W'(b.x) - DIFF_W'(a.x);
        s1_dy_reg  <= DIFF_W'(b.y) - DIFF_W'(a.y);

        s2_idx_reg <= s1_idx_reg;
        s2_a_reg   <= s1_a_reg;
        s2_px_reg  <= PROD_W'(s1_dx_reg) * PROD_W'(t_s);
        s2_py_reg  <= PROD_W'(s1_dy_reg) * PROD_W'(t_s);
    end

    // floor(t*d / 2^16) is the arithmetic shift; the sum stays inside [a, b]
    assign res.x       = s2_a_reg.x + coord_t'(s2_px_reg[FRAC_W +: COORD_W]);
    assign res.y       = s2_a_reg.y + coord_t'(s2_py_reg[FRAC_W +: COORD_W]);
    assign out_tag.vld = s2_vld_reg;
    assign out_tag.idx = s2_idx_reg;
    assign busy        = s1_vld_reg | s2_vld_reg;

endmodule

// ----- sim/bezier_point_checker.sv -----
`timescale 1ns / 1ps

module bezier_point_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  bcpe_pkg::in_t              in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  bcpe_pkg::out_t             out_data,
    input  logic                       cfg_write,
    input  logic [bcpe_pkg::CNT_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending
);
    import bcpe_pkg::*;

    coord_t            ctrl_x [MAX_POINTS];
    coord_t            ctrl_y [MAX_POINTS];
    logic [CNT_W-1:0]  active_count;
    out_t              expected_points [$];
    out_t              oldest;

    // a + floor(t * (b - a) / 2^16); arithmetic shift gives the floor
    function automatic longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> FRAC_W);
    endfunction

    function automatic out_t curve_point(logic [T_W-1:0] t_raw);
        longint wx [MAX_POINTS];
        longint wy [MAX_POINTS];
        longint t;
        int     n;
        out_t   pt;
        if (active_count == 0)
            n = 1;
        else if (active_count > MAX_CNT)
            n = MAX_POINTS;
        else
            n = int'(active_count);
        t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
        for (int i = 0; i < n; i++)
        begin
            wx[i] = ctrl_x[i];
            wy[i] = ctrl_y[i];
        end
        for (int lvl = n; lvl > 1; lvl--)
        begin
            for (int i = 0; i < lvl - 1; i++)
            begin
                wx[i] = blend(wx[i], wx[i + 1], t);
                wy[i] = blend(wy[i], wy[i + 1], t);
            end
        end
        pt.curve_x = COORD_W'(wx[0]);
        pt.curve_y = COORD_W'(wy[0]);
        return pt;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: curve point mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count = 1;
            expected_points.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch($sformatf("result (%0d, %0d) with no evaluation pending",
                                              out_data.curve_x, out_data.curve_y));
                end
                else
                begin
                    oldest = expected_points.pop_front();
                    if (out_data.curve_x !== oldest.curve_x)
                        report_mismatch($sformatf("curve_x got %0d, expected %0d",
                                                  out_data.curve_x, oldest.curve_x));
                    if (out_data.curve_y !== oldest.curve_y)
                        report_mismatch($sformatf("curve_y got %0d, expected %0d",
                                                  out_data.curve_y, oldest.curve_y));
                end
            end
            if (cfg_write)
                active_count = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (in_data.cmd == CMD_WRITE)
                begin
                    if (in_data.point_index < MAX_POINTS)
                    begin
                        ctrl_x[in_data.point_index] = in_data.point_x;
                        ctrl_y[in_data.point_index] = in_data.point_y;
                    end
                end
                else
                begin
                    expected_points.push_back(curve_point(in_data.param_t));
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

// ----- sim/tb_bezier_curve_point_evaluator.sv -----
`timescale 1ns / 1ps

module tb_bezier_curve_point_evaluator;
    import bcpe_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 220;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 20;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_write = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending_evals;
    int idle_rate   = 0;
    int stall_left  = 0;
    int quiet_count = 0;
    int n_writes    = 0;
    int n_evals     = 0;
    int n_settings  = 0;

    always #5 clk = ~clk;

    bezier_curve_point_evaluator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    bezier_point_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .mismatches (fail_count),
        .pending    (pending_evals)
    );

    // watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_count, pending_evals);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall  = 1'b1;
        end
        else if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall  = 1'b1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return T_ONE;
            2:       return T_W'($urandom_range(65537, 131071));
            default: return T_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic in_t point_write(logic [3:0] slot, coord_t x, coord_t y);
        in_t it;
        it.cmd         = CMD_WRITE;
        it.point_index = slot;
        it.point_x     = x;
        it.point_y     = y;
        it.param_t     = T_W'($urandom);
        return it;
    endfunction

    function automatic in_t curve_eval(logic [T_W-1:0] t);
        in_t it;
        it.cmd         = CMD_EVAL;
        it.point_index = 4'($urandom);
        it.point_x     = coord_t'($urandom);
        it.point_y     = coord_t'($urandom);
        it.param_t     = t;
        return it;
    endfunction

    task automatic send_item(in_t item);
        if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
            repeat ($urandom_range(1, 13)) @(negedge clk);
        in_valid = 1'b1;
        in_data  = item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        if (item.cmd == CMD_WRITE)
            n_writes++;
        else
            n_evals++;
    endtask

    // last result out, then room for a write still in flight
    task automatic wait_drained();
        while (pending_evals != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_point_count(logic [CNT_W-1:0] value);
        wait_drained();
        cfg_write = 1'b1;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        n_settings++;
    endtask

    initial
    begin
        logic [CNT_W-1:0] count_plan [5];
        logic [CNT_W-1:0] cnt;
        count_plan = '{5'd1, 5'd2, 5'd0, 5'd31, 5'd17};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every slot with alternating extremes so no read hits an empty slot
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (i % 2 == 0)
                send_item(point_write(4'(i), COORD_MAX, COORD_MIN));
            else
                send_item(point_write(4'(i), COORD_MIN, COORD_MAX));
        end
        // reset count of one: result is slot 0, t above one saturates
        send_item(curve_eval('0));
        send_item(curve_eval('1));

        set_point_count(MAX_CNT);
        send_item(curve_eval('0));
        send_item(curve_eval(T_W'(1)));
        send_item(curve_eval(T_W'(32768)));
        send_item(curve_eval(T_W'(65535)));
        send_item(curve_eval(T_ONE));
        send_item(curve_eval('1));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 5)
                cnt = count_plan[ph];
            else if ($urandom_range(0, 9) == 0)
                cnt = MAX_CNT;
            else
                cnt = CNT_W'($urandom_range(1, 6));
            set_point_count(cnt);

            if (ph >= NUM_PHASES - 2)
                idle_rate = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_rate = 0;
                    1:       idle_rate = 3;
                    default: idle_rate = 8;
                endcase

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 45)
                    send_item(curve_eval(rand_param()));
                else
                    send_item(point_write(4'($urandom), rand_coord(), rand_coord()));
            end
        end

        idle_rate = 0;
        wait_drained();

        $display("Covered %0d control point writes and %0d curve evaluations", n_writes, n_evals);
        $display("over %0d curve length settings, saturating counts and t above one included.",
                 n_settings);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
